/* design/mbrv_pkg.sv */
// ----------------------------------------------------------------------------
// Modbus RTU request validator package
// Beat types, protocol constants and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package mbrv_pkg;

	// One received byte and its start-of-frame marker.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} mbrv_req_t;

	// One frame verdict.
	typedef struct packed {
		logic       accepted;
		logic [7:0] frame_len;
	} mbrv_res_t;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] FN_READ_HOLDING = 8'h03;
	localparam logic [7:0] FN_WRITE_MULTI  = 8'h10;

	localparam logic [7:0] SLAVE_ADDR_RESET = 8'd1;

	// Frame lengths: a read request is fixed, a write request carries
	// two data bytes per register plus a fixed overhead.
	localparam int          FRAME_LEN_MAX  = 255;
	localparam int          WRITE_LEN_BASE = 9;
	localparam logic [7:0]  READ_LEN       = 8'd8;
	localparam logic [7:0]  WRITE_BASE     = 8'(WRITE_LEN_BASE);
	localparam logic [7:0]  QTY_LIMIT      = 8'((FRAME_LEN_MAX - WRITE_LEN_BASE) / 2);

	// Byte positions inside the request that carry decoded fields.
	localparam logic [7:0] POS_ADDR   = 8'd0;
	localparam logic [7:0] POS_FUNC   = 8'd1;
	localparam logic [7:0] POS_QTY_HI = 8'd4;
	localparam logic [7:0] POS_QTY_LO = 8'd5;

	// Reflected CRC-16 over one byte, least significant bit first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
			input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

/* design/modbus_rtu_request_validator_unit.sv */
// ----------------------------------------------------------------------------
// Modbus RTU request validator
// Checks address, function code, length and CRC-16 of incoming requests.
// ----------------------------------------------------------------------------
// Path: the byte deciding a verdict is held in the input register, and the
// verdict is registered in the result register before it is shown on res.
// Throughput: one byte beat per cycle unless res stalls; the byte-wide CRC
// update and field decode sit between the input and result registers.
// Reset: arst_n clears all control and frame state asynchronously; the block
// comes out idle with the slave address at 1 and no clearing pass.
module modbus_rtu_request_validator_unit (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration: slave address write.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data,
	// Request byte channel.
	input  logic               req_valid,
	output logic               req_stall,
	input  mbrv_pkg::mbrv_req_t req,
	// Verdict channel.
	output logic               res_valid,
	input  logic               res_stall,
	output mbrv_pkg::mbrv_res_t res
);
	import mbrv_pkg::*;

	// Configuration register. Write it only while the block is idle;
	// the block does not enforce this, and the port never holds off a write.
	logic [7:0] slave_addr_q;

	// Input register stage.
	logic      valid_s1;
	mbrv_req_t req_s1;

	// Frame state carried between bytes.
	logic        active_q;
	logic [7:0]  pos_q;
	logic [15:0] crc_q;
	logic [7:0]  exp_len_q;
	logic [7:0]  fn_q;
	logic [7:0]  qty_hi_q;

	// Result register.
	logic      res_valid_q;
	mbrv_res_t res_q;

	// Decode of the byte held in the input register.
	logic        out_free;
	logic        advance;
	logic        start;
	logic        live;
	logic [7:0]  pos_cur;
	logic [15:0] crc_cur;
	logic [15:0] crc_new;
	logic [7:0]  fn_cur;
	logic [7:0]  exp_cur;
	logic [7:0]  qhi_cur;
	logic [7:0]  fn_nxt;
	logic [7:0]  exp_nxt;
	logic [7:0]  qhi_nxt;
	logic        reject;
	logic        complete;
	logic        done;
	mbrv_res_t   verdict;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= SLAVE_ADDR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			slave_addr_q <= cfg_data;
		end
	end

	// The result register can take a new verdict when it is empty or its
	// current beat leaves this cycle. The input stage moves on under the
	// same condition, so only downstream backpressure stalls the request side.
	assign out_free  = !res_valid_q || !res_stall;
	assign advance   = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall) begin
			req_s1 <= req;
		end
	end

	// A start-of-frame byte begins from the idle state, dropping any
	// partial frame; a byte with no frame open is ignored.
	assign start   = req_s1.frame_start;
	assign live    = start || active_q;
	assign pos_cur = start ? POS_ADDR : pos_q;
	assign crc_cur = start ? CRC_INIT : crc_q;
	assign fn_cur  = start ? 8'h00 : fn_q;
	assign exp_cur = start ? 8'h00 : exp_len_q;
	assign qhi_cur = start ? 8'h00 : qty_hi_q;
	assign crc_new = crc16_byte(crc_cur, req_s1.rx_byte);

	always_comb begin
		fn_nxt  = fn_cur;
		exp_nxt = exp_cur;
		qhi_nxt = qhi_cur;
		reject  = 1'b0;
		case (pos_cur)
			POS_ADDR: begin
				if (req_s1.rx_byte != slave_addr_q) begin
					reject = 1'b1;
				end
			end
			POS_FUNC: begin
				fn_nxt = req_s1.rx_byte;
				if (req_s1.rx_byte == FN_READ_HOLDING) begin
					exp_nxt = READ_LEN;
				end else if (req_s1.rx_byte != FN_WRITE_MULTI) begin
					reject = 1'b1;
				end
			end
			POS_QTY_HI: begin
				if (fn_cur == FN_WRITE_MULTI) begin
					qhi_nxt = req_s1.rx_byte;
				end
			end
			POS_QTY_LO: begin
				// The write length 2*quantity+9 fits in a byte only when the
				// high quantity byte is zero and the low byte is small enough.
				if (fn_cur == FN_WRITE_MULTI) begin
					if (qhi_cur != 8'h00 || req_s1.rx_byte > QTY_LIMIT) begin
						reject = 1'b1;
					end else begin
						exp_nxt = {req_s1.rx_byte[6:0], 1'b0} + WRITE_BASE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// The last byte of a frame is the one whose position reaches the known
	// length; the CRC over the whole frame, trailer included, must be zero.
	assign complete = !reject && (exp_nxt != 8'h00) && (pos_cur + 8'd1 == exp_nxt);
	assign done     = reject || complete;

	always_comb begin
		verdict.accepted  = complete && (crc_new == 16'h0000);
		verdict.frame_len = verdict.accepted ? exp_nxt : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			pos_q     <= 8'h00;
			crc_q     <= CRC_INIT;
			exp_len_q <= 8'h00;
			fn_q      <= 8'h00;
			qty_hi_q  <= 8'h00;
		end else if (advance && live) begin
			if (done) begin
				active_q  <= 1'b0;
				pos_q     <= 8'h00;
				crc_q     <= CRC_INIT;
				exp_len_q <= 8'h00;
				fn_q      <= 8'h00;
				qty_hi_q  <= 8'h00;
			end else begin
				active_q  <= 1'b1;
				pos_q     <= pos_cur + 8'd1;
				crc_q     <= crc_new;
				exp_len_q <= exp_nxt;
				fn_q      <= fn_nxt;
				qty_hi_q  <= qhi_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1 && live && done;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			res_q <= verdict;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// A rejected frame always reports a zero length.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.accepted |-> res_q.frame_len == 8'h00)
		else $error("rejected verdict with nonzero length");

	// No accepted frame is shorter than a read request.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.accepted |-> res_q.frame_len >= READ_LEN)
		else $error("accepted frame shorter than minimum");

	// While idle the frame state sits at its starting values.
	assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> pos_q == 8'h00 && crc_q == CRC_INIT && exp_len_q == 8'h00)
		else $error("idle with stale frame state");

	// The request side is held off only by a verdict waiting downstream.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> res_valid_q && res_stall)
		else $error("request stalled without downstream backpressure");

	// A stalled request byte stays in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |=> valid_s1 && $stable(req_s1))
		else $error("input register changed while stalled");

endmodule

/* verif/modbus_rtu_request_validator_unit_test.sv */
// ----------------------------------------------------------------------------
// Modbus RTU request validator testbench
// Streams request bytes into the validator under random gaps and stalls.
// A bit-serial CRC model predicts every verdict, and each verdict beat is
// checked in order. The slave address is changed between phases, only
// while the block is idle.
// ----------------------------------------------------------------------------
module modbus_rtu_request_validator_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mbrv_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	// Cycles without any beat on any channel before the run is abandoned.
	localparam int QUIET_LIMIT = 2000;
	// Margin after the last verdict for the input and result registers to drain.
	localparam int SETTLE_CYCLES = 4;
	// Frame bytes sent in each random phase.
	localparam int WORK_PER_PHASE = 100;
	localparam int PHASES = 5;

	// Predicts the verdict stream from the accepted request bytes and holds
	// the verdicts that are still owed by the block.
	class verdict_scoreboard;
		logic [7:0] station;
		logic [7:0] pos;
		logic [15:0] crc;
		logic [7:0] want_len;
		logic [7:0] fcode;
		logic [7:0] qty_hi;
		bit in_frame;
		mbrv_res_t due_q[$];
		int errors;
		int checked;
		int passed;

		function new();
			station = SLAVE_ADDR_RESET;
			errors = 0;
			checked = 0;
			passed = 0;
			close_frame();
		endfunction

		// Modbus CRC-16, one data bit at a time, least significant bit first.
		static function logic [15:0] crc_fold(logic [15:0] acc, logic [7:0] b);
			logic [15:0] c;
			c = acc;
			for (int i = 0; i < 8; i++) begin
				if (c[0] ^ b[i]) begin
					c = (c >> 1) ^ CRC_POLY;
				end else begin
					c = c >> 1;
				end
			end
			return c;
		endfunction

		function void close_frame();
			in_frame = 1'b0;
			pos = '0;
			crc = CRC_INIT;
			want_len = '0;
			fcode = '0;
			qty_hi = '0;
		endfunction

		function void post_verdict(logic ok, logic [7:0] len);
			mbrv_res_t v;
			v.accepted = ok;
			v.frame_len = len;
			due_q.push_back(v);
			close_frame();
		endfunction

		function void set_address(logic [7:0] a);
			station = a;
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		// Notes one accepted request beat.
		function void note_byte(mbrv_req_t r);
			int total;
			if (r.frame_start) begin
				close_frame();
				in_frame = 1'b1;
			end else if (!in_frame) begin
				return;
			end
			crc = crc_fold(crc, r.rx_byte);
			case (pos)
				POS_ADDR: begin
					if (r.rx_byte != station) begin
						post_verdict(1'b0, 8'd0);
						return;
					end
				end
				POS_FUNC: begin
					fcode = r.rx_byte;
					if (r.rx_byte == FN_READ_HOLDING) begin
						want_len = READ_LEN;
					end else if (r.rx_byte != FN_WRITE_MULTI) begin
						post_verdict(1'b0, 8'd0);
						return;
					end
				end
				POS_QTY_HI: begin
					if (fcode == FN_WRITE_MULTI) qty_hi = r.rx_byte;
				end
				POS_QTY_LO: begin
					if (fcode == FN_WRITE_MULTI) begin
						total = 2 * int'({qty_hi, r.rx_byte}) + WRITE_LEN_BASE;
						if (total > FRAME_LEN_MAX) begin
							post_verdict(1'b0, 8'd0);
							return;
						end
						want_len = 8'(total);
					end
				end
				default: ;
			endcase
			if (want_len != 0 && int'(pos) + 1 == int'(want_len)) begin
				if (crc == 16'h0000) begin
					post_verdict(1'b1, want_len);
				end else begin
					post_verdict(1'b0, 8'd0);
				end
				return;
			end
			pos = pos + 8'd1;
		endfunction

		task report_mismatch(string what);
			errors++;
			$display("tb: mismatch at %0t ns: %s", $time, what);
		endtask

		// Checks one accepted verdict beat against the oldest one owed.
		task check_verdict(mbrv_res_t got);
			mbrv_res_t want;
			if (due_q.size() == 0) begin
				report_mismatch($sformatf("verdict accepted=%0b len=%0d with none owed",
					got.accepted, got.frame_len));
				return;
			end
			want = due_q.pop_front();
			checked++;
			if (want.accepted) passed++;
			if (got.accepted !== want.accepted) begin
				report_mismatch($sformatf("accepted is %0b, predicted %0b",
					got.accepted, want.accepted));
			end
			if (got.frame_len !== want.frame_len) begin
				report_mismatch($sformatf("frame_len is %0d, predicted %0d",
					got.frame_len, want.frame_len));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	mbrv_req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	mbrv_res_t res;

	verdict_scoreboard sb = new();

	// When set, neither side inserts gaps or stalls.
	bit calm = 1'b0;
	logic [7:0] cur_addr = SLAVE_ADDR_RESET;
	int bytes_sent = 0;
	int frame_bytes = 0;
	int quiet_cycles = 0;

	modbus_rtu_request_validator_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// The verdict side stalls about a quarter of the time, except in calm
	// stretches. A fresh decision every cycle puts stalls on every phase of
	// a frame.
	always @(posedge clk) begin
		res_stall <= !calm && ($urandom_range(99) < 25);
	end

	// Monitor. Signals are sampled at the edge before any nonblocking update
	// of that edge lands, so a beat is seen exactly as the block sees it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) sb.note_byte(req);
			if (res_valid && !res_stall) sb.check_verdict(res);
		end
	end

	// Watchdog: a hung handshake on any channel ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (res_valid && !res_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("tb: no beat for %0d cycles, %0d verdicts still owed",
						quiet_cycles, sb.pending());
					$display("tb: failure");
					$finish;
				end
			end
		end
	end

	// Drives one request beat and returns at the edge that accepts it. The
	// valid stays high on return, so back-to-back beats need no second
	// assignment in the same step; whoever pauses next lowers it.
	task automatic push_byte(input logic [7:0] b, input logic s);
		if (!calm && $urandom_range(99) < 25) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		req <= '{rx_byte: b, frame_start: s};
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		bytes_sent++;
	endtask

	// A frame: the start flag goes on its first byte only.
	task automatic send_frame(input byte_q_t f);
		foreach (f[i]) push_byte(f[i], i == 0);
		frame_bytes += f.size();
	endtask

	// Bytes with no start flag, which the block drops while no frame is open.
	task automatic send_loose(input byte_q_t f);
		foreach (f[i]) push_byte(f[i], 1'b0);
	endtask

	// Stops the request side and waits until every owed verdict has come,
	// plus the pipeline depth, so that the block is surely idle. The first
	// edge lets the monitor note the last accepted byte before the count
	// of owed verdicts is read.
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_address(input logic [7:0] a);
		cfg_data <= a;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_address(a);
		cur_addr = a;
	endtask

	// Appends the CRC, low byte first, so that the residue comes out zero.
	function automatic void seal(ref byte_q_t f);
		logic [15:0] c;
		c = CRC_INIT;
		foreach (f[i]) c = verdict_scoreboard::crc_fold(c, f[i]);
		f.push_back(c[7:0]);
		f.push_back(c[15:8]);
	endfunction

	function automatic void make_read(input logic [7:0] a, ref byte_q_t f);
		f = '{a, FN_READ_HOLDING, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom)};
		seal(f);
	endfunction

	function automatic void make_write(input logic [7:0] a, input logic [15:0] qty,
			ref byte_q_t f);
		f = '{a, FN_WRITE_MULTI, 8'($urandom), 8'($urandom), qty[15:8], qty[7:0],
			8'(2 * qty)};
		repeat (2 * int'(qty)) f.push_back(8'($urandom));
		seal(f);
	endfunction

	// A well-formed request for the current address. Writes are mostly
	// short; now and then one runs long to exercise the length counter.
	function automatic void make_good(ref byte_q_t f);
		if ($urandom_range(1)) begin
			make_read(cur_addr, f);
		end else if ($urandom_range(99) < 3) begin
			make_write(cur_addr, 16'($urandom_range(7, 123)), f);
		end else begin
			make_write(cur_addr, 16'($urandom_range(0, 6)), f);
		end
	endfunction

	// One random piece of traffic. Half are clean frames; they and frames with
	// a flipped bit past the header reach the CRC verdict. The rest damage a
	// frame in another way, trail a clean frame with loose bytes, or are plain line noise.
	task automatic send_random_frame();
		byte_q_t f;
		byte_q_t tail;
		int pick;
		int k;
		logic [7:0] b;
		pick = $urandom_range(99);
		make_good(f);
		if (pick < 50) begin
			send_frame(f);
		end else if (pick < 60) begin
			// One flipped bit anywhere; usually caught by the CRC, but a hit
			// on the header gives an earlier rejection.
			k = $urandom_range(f.size() - 1);
			f[k] = f[k] ^ 8'(1 << $urandom_range(7));
			send_frame(f);
		end else if (pick < 66) begin
			f[0] = cur_addr ^ 8'($urandom_range(1, 255));
			send_frame(f);
		end else if (pick < 72) begin
			do b = 8'($urandom); while (b == FN_READ_HOLDING || b == FN_WRITE_MULTI);
			f[1] = b;
			send_frame(f);
		end else if (pick < 77) begin
			// Write whose quantity pushes the length past 255 bytes; the
			// bytes behind the rejection land on an idle block.
			k = $urandom_range(124, 65535);
			f = '{cur_addr, FN_WRITE_MULTI, 8'($urandom), 8'($urandom), 8'(k >> 8),
				8'(k), 8'($urandom), 8'($urandom)};
			send_frame(f);
		end else if (pick < 86) begin
			// Cut short; the next start flag abandons what is left open.
			k = $urandom_range(1, f.size() - 1);
			while (f.size() > k) void'(f.pop_back());
			send_frame(f);
		end else if (pick < 93) begin
			// Trailing bytes after a finished frame are dropped.
			send_frame(f);
			repeat ($urandom_range(1, 3)) tail.push_back(8'($urandom));
			send_loose(tail);
		end else begin
			// Noise with random start flags; a frame left open by earlier
			// traffic may pick some of it up.
			repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		byte_q_t f;
		logic [7:0] plan [PHASES];
		int target;

		plan[0] = 8'h00;
		plan[1] = 8'hFF;
		plan[2] = 8'($urandom);
		plan[3] = 8'($urandom);
		plan[4] = SLAVE_ADDR_RESET;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed traffic, all at the reset address.
		// A byte with no frame open produces nothing.
		f = '{8'hFF};
		send_loose(f);
		// Wrong address on the first byte.
		f = '{8'h00};
		send_frame(f);
		// Right address, unknown function code.
		f = '{cur_addr, 8'hFF};
		send_frame(f);
		// A read header that is abandoned by the start of the next frame.
		f = '{cur_addr, FN_READ_HOLDING};
		send_frame(f);
		// Clean read with all-zero and all-one body bytes.
		f = '{cur_addr, FN_READ_HOLDING, 8'h00, 8'h00, 8'hFF, 8'hFF};
		seal(f);
		send_frame(f);
		// Write with zero quantity is still a valid 9-byte frame.
		f = '{cur_addr, FN_WRITE_MULTI, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
		seal(f);
		send_frame(f);
		// Quantity 124 is the first that does not fit in 255 bytes.
		f = '{cur_addr, FN_WRITE_MULTI, 8'h00, 8'h00, 8'h00, 8'h7C};
		send_frame(f);
		// Hold the sender until every verdict is back before reconfiguring.
		settle();

		// Random phases, each at its own slave address. The middle phase
		// runs with no gaps and no stalls at all.
		for (int p = 0; p < PHASES; p++) begin
			write_address(plan[p]);
			calm = (p == 2);
			target = frame_bytes + WORK_PER_PHASE;
			if (p == 3) begin
				// The longest legal frame, 255 bytes.
				make_write(cur_addr, 16'd123, f);
				send_frame(f);
			end
			while (frame_bytes < target) send_random_frame();
			settle();
		end
		calm = 1'b0;

		if (sb.pending() != 0) begin
			sb.report_mismatch($sformatf("%0d verdicts never arrived", sb.pending()));
		end
		$display("tb: %0d request bytes sent, %0d verdicts checked, %0d accepted frames",
			bytes_sent, sb.checked, sb.passed);
		$display("tb: covered reset address plus slave addresses 0x00, 0xFF and two random ones");
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
